FILE: rtl/core/svm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svm_pkg
// Shared widths, opcode codes and the result record of the small vm step.
// ----------------------------------------------------------------------------
package svm_pkg;

   localparam int SVM_ADDR_W   = 12;
   localparam int SVM_WORD_W   = 16;
   localparam int SVM_DATA_W   = 8;
   localparam int SVM_IDX_W    = 4;
   localparam int SVM_NUM_REGS = 16;

   localparam logic [SVM_ADDR_W-1:0] SVM_START_RESET = 12'h200;

   // major opcodes, top nibble of the instruction word
   localparam logic [3:0] OP_JUMP    = 4'h1;
   localparam logic [3:0] OP_SKIP_EQ = 4'h3;
   localparam logic [3:0] OP_SKIP_NE = 4'h4;
   localparam logic [3:0] OP_SKIP_RR = 4'h5;
   localparam logic [3:0] OP_LOAD    = 4'h6;
   localparam logic [3:0] OP_ADD     = 4'h7;
   localparam logic [3:0] OP_ALU     = 4'h8;

   // register-register sub-operations, low nibble
   localparam logic [3:0] ALU_COPY = 4'h0;
   localparam logic [3:0] ALU_OR   = 4'h1;
   localparam logic [3:0] ALU_AND  = 4'h2;
   localparam logic [3:0] ALU_XOR  = 4'h3;

   typedef struct packed {
      logic [SVM_ADDR_W-1:0] next_address;
      logic                  skip_taken;
      logic                  reg_write;
      logic [SVM_IDX_W-1:0]  reg_index;
      logic [SVM_DATA_W-1:0] reg_value;
   } svm_result_type;

endpackage
`default_nettype wire

FILE: rtl/core/svm_exec.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svm_exec
// Decode and execute of one instruction word against its two register
// operands and the current program address.
// ----------------------------------------------------------------------------
module svm_exec (
   input  wire logic [svm_pkg::SVM_WORD_W-1:0] instr_word,
   input  wire logic [svm_pkg::SVM_DATA_W-1:0] vx,
   input  wire logic [svm_pkg::SVM_DATA_W-1:0] vy,
   input  wire logic [svm_pkg::SVM_ADDR_W-1:0] fetch_address,
   output svm_pkg::svm_result_type              result
);
   import svm_pkg::*;

   logic [3:0]            op;
   logic [SVM_IDX_W-1:0]  x_idx;
   logic [3:0]            n_sub;
   logic [SVM_DATA_W-1:0] nn;
   logic [SVM_ADDR_W-1:0] seq_addr;
   logic                  skip;
   logic                  wr;
   logic [SVM_DATA_W-1:0] val;

   // instruction fields
   assign op       = instr_word[15:12];
   assign x_idx    = instr_word[11:8];
   assign n_sub    = instr_word[3:0];
   assign nn       = instr_word[7:0];
   assign seq_addr = fetch_address + SVM_ADDR_W'(2);

   // decode: skip condition and register write
   always_comb begin
      skip = 1'b0;
      wr   = 1'b0;
      val  = '0;
      unique case (op)
         OP_SKIP_EQ: skip = (vx == nn);
         OP_SKIP_NE: skip = (vx != nn);
         OP_SKIP_RR: skip = (n_sub == 4'h0) && (vx == vy);
         OP_LOAD: begin
            wr  = 1'b1;
            val = nn;
         end
         OP_ADD: begin
            wr  = 1'b1;
            val = vx + nn;
         end
         OP_ALU: begin
            unique case (n_sub)
               ALU_COPY: begin
                  wr  = 1'b1;
                  val = vy;
               end
               ALU_OR: begin
                  wr  = 1'b1;
                  val = vx | vy;
               end
               ALU_AND: begin
                  wr  = 1'b1;
                  val = vx & vy;
               end
               ALU_XOR: begin
                  wr  = 1'b1;
                  val = vx ^ vy;
               end
               default: wr = 1'b0;
            endcase
         end
         default: skip = 1'b0;
      endcase
   end

   // next address and result record
   always_comb begin
      if (op == OP_JUMP) begin
         result.next_address = instr_word[SVM_ADDR_W-1:0];
      end else if (skip) begin
         result.next_address = seq_addr + SVM_ADDR_W'(2);
      end else begin
         result.next_address = seq_addr;
      end
      result.skip_taken = skip;
      result.reg_write  = wr;
      result.reg_index  = wr ? x_idx : '0;
      result.reg_value  = wr ? val : '0;
   end

endmodule
`default_nettype wire

FILE: rtl/core/small_vm_instruction_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// small_vm_instruction_step
// One instruction step of a small 8-bit interpreter machine subset.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one instruction word per transfer (valid/stall, stall driven here).
//   rsp_*  : one result per instruction: next address, skip flag and the
//            data register write, if any (valid/stall, stall driven by sink).
//   csr_*  : write of the start address; it also reloads the program address.
//            csr_ready is always high; write only while the block is idle.
// Path: a request transfer reads the synchronous register file into the read
//   stage registers; execute then writes its result into the output register,
//   and a stalled output can hold the read stage between the two.
// Throughput: one instruction per cycle unless the output stalls. The sixteen
//   data registers sit in a two-read, one-write memory; a write from the
//   previous instruction is forwarded to the next one whose read it overlapped.
// Reset: program address loads 0x200 and all data registers read as zero
//   (per-entry valid bits); nothing is in flight.
// Stall: a stalled result holds in the output register; the execute stage
//   and then the request side stall behind it, nothing is dropped.
// ----------------------------------------------------------------------------
module small_vm_instruction_step (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output      logic                            req_stall,
   input  wire logic [svm_pkg::SVM_WORD_W-1:0]  req_instruction_word,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   output      logic [svm_pkg::SVM_ADDR_W-1:0]  rsp_next_address,
   output      logic                            rsp_skip_taken,
   output      logic                            rsp_reg_write,
   output      logic [svm_pkg::SVM_IDX_W-1:0]   rsp_reg_index,
   output      logic [svm_pkg::SVM_DATA_W-1:0]  rsp_reg_value,
   input  wire logic                            csr_valid,
   output      logic                            csr_ready,
   input  wire logic [svm_pkg::SVM_ADDR_W-1:0]  csr_start_address
);
   import svm_pkg::*;

   // register file memory and its valid bits
   logic [SVM_DATA_W-1:0]   regs_mem [SVM_NUM_REGS];
   logic [SVM_NUM_REGS-1:0] regs_valid_ff;
   logic [SVM_NUM_REGS-1:0] regs_valid_in;

   // read stage
   logic [SVM_DATA_W-1:0]   rd_x_ff;
   logic [SVM_DATA_W-1:0]   rd_y_ff;
   logic                    rd_x_valid_ff;
   logic                    rd_y_valid_ff;
   logic [SVM_WORD_W-1:0]   s1_word_ff;
   logic                    s1_valid_ff;
   logic                    s1_valid_in;

   // forwarding of the last retired write
   logic                    fwd_valid_ff;
   logic                    fwd_valid_in;
   logic [SVM_IDX_W-1:0]    fwd_idx_ff;
   logic [SVM_DATA_W-1:0]   fwd_val_ff;

   // program address and output register
   logic [SVM_ADDR_W-1:0]   fetch_address_ff;
   logic [SVM_ADDR_W-1:0]   fetch_address_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   svm_result_type          rsp_ff;
   svm_result_type          result;

   logic                    req_xfer;
   logic                    csr_xfer;
   logic                    s1_adv;
   logic [SVM_IDX_W-1:0]    req_x;
   logic [SVM_IDX_W-1:0]    req_y;
   logic [SVM_IDX_W-1:0]    s1_x;
   logic [SVM_IDX_W-1:0]    s1_y;
   logic [SVM_DATA_W-1:0]   vx;
   logic [SVM_DATA_W-1:0]   vy;

   // handshake
   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_xfer  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_xfer  = csr_valid && csr_ready;

   assign req_x = req_instruction_word[11:8];
   assign req_y = req_instruction_word[7:4];
   assign s1_x  = s1_word_ff[11:8];
   assign s1_y  = s1_word_ff[7:4];

   // register file read on request transfer, registered data
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rd_x_ff       <= regs_mem[req_x];
         rd_y_ff       <= regs_mem[req_y];
         rd_x_valid_ff <= regs_valid_ff[req_x];
         rd_y_valid_ff <= regs_valid_ff[req_y];
         s1_word_ff    <= req_instruction_word;
      end
   end

   // register file write when the execute stage retires
   always_ff @(posedge clock) begin
      if (s1_adv && result.reg_write) begin
         regs_mem[result.reg_index] <= result.reg_value;
      end
   end

   // operands: forward the write that retired alongside this read
   always_comb begin
      if (fwd_valid_ff && (fwd_idx_ff == s1_x)) begin
         vx = fwd_val_ff;
      end else begin
         vx = rd_x_valid_ff ? rd_x_ff : '0;
      end
      if (fwd_valid_ff && (fwd_idx_ff == s1_y)) begin
         vy = fwd_val_ff;
      end else begin
         vy = rd_y_valid_ff ? rd_y_ff : '0;
      end
   end

   svm_exec u_exec (
      .instr_word    (s1_word_ff),
      .vx            (vx),
      .vy            (vy),
      .fetch_address (fetch_address_ff),
      .result        (result)
   );

   // next-state logic for control registers
   always_comb begin
      s1_valid_in = req_xfer || (s1_valid_ff && !s1_adv);

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end

      fwd_valid_in = fwd_valid_ff;
      if (s1_adv) begin
         fwd_valid_in = result.reg_write;
      end

      regs_valid_in = regs_valid_ff;
      if (s1_adv && result.reg_write) begin
         regs_valid_in[result.reg_index] = 1'b1;
      end

      priority if (csr_xfer) begin
         fetch_address_in = csr_start_address;
      end else if (s1_adv) begin
         fetch_address_in = result.next_address;
      end else begin
         fetch_address_in = fetch_address_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         fwd_valid_ff     <= 1'b0;
         regs_valid_ff    <= '0;
         fetch_address_ff <= SVM_START_RESET;
      end else begin
         s1_valid_ff      <= s1_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
         fwd_valid_ff     <= fwd_valid_in;
         regs_valid_ff    <= regs_valid_in;
         fetch_address_ff <= fetch_address_in;
      end
   end

   // payload registers: forwarding record and output
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         fwd_idx_ff <= result.reg_index;
         fwd_val_ff <= result.reg_value;
         rsp_ff     <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_next_address = rsp_ff.next_address;
   assign rsp_skip_taken   = rsp_ff.skip_taken;
   assign rsp_reg_write    = rsp_ff.reg_write;
   assign rsp_reg_index    = rsp_ff.reg_index;
   assign rsp_reg_value    = rsp_ff.reg_value;

   // checks
   a_no_skip_and_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.skip_taken && rsp_ff.reg_write))
      else $error("skip and register write in one result");

   a_idle_write_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.reg_write) |->
         (rsp_ff.reg_index == '0 && rsp_ff.reg_value == '0))
      else $error("write fields not zero without a register write");

   a_stall_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled with free execute stage");

   a_csr_loads_address: assert property (@(posedge clock) disable iff (reset)
      csr_xfer |=> (fetch_address_ff == $past(csr_start_address)))
      else $error("start address write did not load program address");

   a_result_follows_retire: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> (rsp_valid_ff && rsp_ff.next_address == fetch_address_ff))
      else $error("retired instruction missing from output register");

endmodule
`default_nettype wire
